[rtl/core/efc_pkg.sv]
// Shared types and constants for the escaped frame checker.
`timescale 1ns / 1ps

package efc_pkg;

    // Escape and data byte values
    localparam logic [7:0] ESC_MARK   = 8'hBB;
    localparam logic [7:0] ESC_OF_AA  = 8'h0A;
    localparam logic [7:0] ESC_OF_BB  = 8'h0B;
    localparam logic [7:0] FRAME_MARK = 8'hAA;

    // Byte count saturates at all ones
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] LEN_BYTES = 32'd4;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // Frame status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_ESC = 2'd1,
        STATUS_LEN     = 2'd2,
        STATUS_SUM     = 2'd3
    } status_t;

    // Classified word passed from front to back
    typedef struct packed {
        logic       has_data;   // a decoded byte is carried
        logic [7:0] data;       // decoded byte
        logic       frame_end;  // frame closes after this command
        logic       esc_err;    // a bad escape occurred in this frame
    } cmd_t;

endpackage

[rtl/core/efc_front.sv]
// Front end: input handshake, escape removal and command classification.
`timescale 1ns / 1ps

module efc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              q_full,
    output logic              push,
    output efc_pkg::cmd_t     cmd
);
    import efc_pkg::*;

    logic pend_reg, pend_next;
    logic err_reg, err_next;
    logic accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Escape decode
    always_comb
    begin
        pend_next     = pend_reg;
        err_next      = err_reg;
        cmd           = '0;
        if (accept)
        begin
            if (!err_reg)
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    if (s_tdata == ESC_OF_AA)
                    begin
                        cmd.has_data = 1'b1;
                        cmd.data     = FRAME_MARK;
                    end
                    else if (s_tdata == ESC_OF_BB)
                    begin
                        cmd.has_data = 1'b1;
                        cmd.data     = ESC_MARK;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else if (s_tdata == ESC_MARK)
                begin
                    pend_next = 1'b1;
                end
                else
                begin
                    cmd.has_data = 1'b1;
                    cmd.data     = s_tdata;
                end
            end
            // Frame end: report error, drop any lone escape, start afresh
            if (s_tlast)
            begin
                cmd.frame_end = 1'b1;
                cmd.esc_err   = err_next;
                pend_next     = 1'b0;
                err_next      = 1'b0;
            end
        end
    end

    assign push = accept && (cmd.has_data || cmd.frame_end);

    // Escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            err_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            err_reg  <= err_next;
        end
    end

endmodule

[rtl/core/efc_queue.sv]
// Short command queue decoupling front and back.
`timescale 1ns / 1ps

module efc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  efc_pkg::cmd_t     push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output efc_pkg::cmd_t     head
);
    import efc_pkg::*;

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;

    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[rtl/core/efc_back.sv]
// Back end: running length and checksum, result word generation.
`timescale 1ns / 1ps

module efc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  efc_pkg::cmd_t     cmd,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);
    import efc_pkg::*;

    logic [31:0] count_reg, count_next;
    logic [31:0] length_reg, length_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  prev_reg, prev_next;
    logic        phase_reg, phase_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;
    status_t     out_code_reg, out_code_next;
    logic        out_status_reg, out_status_next;

    logic        load;
    status_t     code;

    assign load = !out_valid_reg || m_tready;

    // Frame checks on the current running state
    always_comb
    begin
        priority if (cmd.esc_err)
            code = STATUS_BAD_ESC;
        else if (count_reg < LEN_BYTES || length_reg != count_reg - 32'd1)
            code = STATUS_LEN;
        else if (sum_reg != prev_reg)
            code = STATUS_SUM;
        else
            code = STATUS_OK;
    end

    // Command execution
    always_comb
    begin
        count_next      = count_reg;
        length_next     = length_reg;
        sum_next        = sum_reg;
        prev_next       = prev_reg;
        phase_next      = phase_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_code_next   = out_code_reg;
        out_status_next = out_status_reg;
        pop             = 1'b0;
        if (cmd_valid && load)
        begin
            if (!phase_reg && cmd.has_data)
            begin
                // Data word, fold byte into running state
                out_valid_next  = 1'b1;
                out_data_next   = cmd.data;
                out_code_next   = STATUS_OK;
                out_status_next = 1'b0;
                if (count_reg != '0)
                    sum_next = sum_reg + prev_reg;
                if (count_reg < LEN_BYTES)
                    length_next = {length_reg[23:0], cmd.data};
                prev_next = cmd.data;
                if (count_reg != COUNT_MAX)
                    count_next = count_reg + 32'd1;
                if (cmd.frame_end)
                    phase_next = 1'b1;
                else
                    pop = 1'b1;
            end
            else
            begin
                // Status word, then clear frame state
                out_valid_next  = 1'b1;
                out_data_next   = '0;
                out_code_next   = code;
                out_status_next = 1'b1;
                count_next      = '0;
                length_next     = '0;
                sum_next        = '0;
                prev_next       = '0;
                phase_next      = 1'b0;
                pop             = 1'b1;
            end
        end
    end

    // Frame state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            length_reg    <= '0;
            sum_reg       <= '0;
            prev_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            length_reg    <= length_next;
            sum_reg       <= sum_next;
            prev_reg      <= prev_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_code_reg   <= out_code_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_code_reg, out_data_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_status_reg;

endmodule

[rtl/core/escaped_frame_checker_core.sv]
// Top level of the escaped frame checker: front, command queue and back.
//
//  channel | dir | tdata bits (low first)            | tuser      | tlast
//  s_*     | in  | rx_byte[7:0]                      | -          | frame_end
//  m_*     | out | data_byte[7:0], status_code[9:8] | is_status  | last
//
// One input word per cycle is accepted while the four-entry command queue
// has room. The back end emits one result word per cycle while a command
// waits and the receiver is ready; a frame's final byte yields a data word
// and then a status word. The output register is reloaded whenever it is
// empty or being taken, so stalls on either side are absorbed by the queue.
// Reset clears all control and frame state at once; no clearing pass is needed.
`timescale 1ns / 1ps

module escaped_frame_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // data_byte[7:0], status_code[9:8], zero pad
    output logic        m_tuser,   // is_status
    output logic        m_tlast
);
    import efc_pkg::*;

    logic q_full, q_not_empty, push, pop;
    cmd_t push_cmd, head_cmd;

    // Decode and classify
    efc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    // Command queue
    efc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    // Checks and results
    efc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[tb/sv/efc_result_checker.sv]
// Channel monitor for the escaped frame checker: predicts result words and compares them.
`timescale 1ns / 1ps

module efc_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte[7:0]
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // data_byte[7:0], status_code[9:8], zero pad
    input  logic        m_tuser,    // is_status
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          words_in,
    output int          bytes_out,
    output int          frames_out,
    output int          frames_ok
);
    import efc_pkg::*;

    // One expected result word
    typedef struct packed {
        logic       is_status;
        logic [7:0] data_byte;
        status_t    code;
        logic       last;
    } frame_result_t;

    frame_result_t expected_q[$];
    frame_result_t want;

    // Shadow copy of the decoder's frame state
    logic        esc_pending;
    logic        esc_error;
    logic [31:0] dec_count;
    logic [31:0] len_field;
    logic [7:0]  sum_prev;
    logic [7:0]  prev_byte;

    task clear_frame_state();
        esc_pending = 1'b0;
        esc_error   = 1'b0;
        dec_count   = '0;
        len_field   = '0;
        sum_prev    = '0;
        prev_byte   = '0;
    endtask

    // Account for one decoded byte and expect it on the output
    task take_decoded(input logic [7:0] b);
        if (dec_count != 32'd0)
            sum_prev = sum_prev + prev_byte;
        if (dec_count < LEN_BYTES)
            len_field = {len_field[23:0], b};
        prev_byte = b;
        if (dec_count != COUNT_MAX)
            dec_count = dec_count + 32'd1;
        expected_q.push_back('{1'b0, b, STATUS_OK, 1'b0});
    endtask

    // Unstuff one received word; close the frame on its final word
    task decode_word(input logic [7:0] b, input logic frame_end);
        status_t code;
        if (!esc_error)
        begin
            if (esc_pending)
            begin
                esc_pending = 1'b0;
                if (b == ESC_OF_AA)
                    take_decoded(FRAME_MARK);
                else if (b == ESC_OF_BB)
                    take_decoded(ESC_MARK);
                else
                    esc_error = 1'b1;
            end
            else if (b == ESC_MARK)
                esc_pending = 1'b1;
            else
                take_decoded(b);
        end
        if (frame_end)
        begin
            if (esc_error)
                code = STATUS_BAD_ESC;
            else if (dec_count < LEN_BYTES || len_field != dec_count - 32'd1)
                code = STATUS_LEN;
            else if (sum_prev != prev_byte)
                code = STATUS_SUM;
            else
                code = STATUS_OK;
            expected_q.push_back('{1'b1, 8'h00, code, 1'b1});
            clear_frame_state();
        end
    endtask

    task check_field(input string name, input logic [31:0] want_v, input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame_state();
            expected_q.delete();
            fail_count = 0;
            pending    = 0;
            words_in   = 0;
            bytes_out  = 0;
            frames_out = 0;
            frames_ok  = 0;
        end
        else
        begin
            // Result side first: a word leaving now cannot stem from this edge's input
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result word: tdata %h tuser %b tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("is_status", 32'(want.is_status), 32'(m_tuser));
                    check_field("data_byte", 32'(want.data_byte), 32'(m_tdata[7:0]));
                    check_field("status_code", 32'(want.code), 32'(m_tdata[9:8]));
                    check_field("last", 32'(want.last), 32'(m_tlast));
                    check_field("tdata pad", 32'd0, 32'(m_tdata[15:10]));
                    if (want.is_status)
                    begin
                        frames_out++;
                        if (want.code == STATUS_OK)
                            frames_ok++;
                    end
                    else
                        bytes_out++;
                end
            end
            // Input side
            if (s_tvalid && s_tready)
            begin
                words_in++;
                decode_word(s_tdata, s_tlast);
            end
            pending = expected_q.size();
        end
    end

endmodule

[tb/sv/escaped_frame_checker_core_test.sv]
// Testbench top for the escaped frame checker: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module escaped_frame_checker_core_test;
    import efc_pkg::*;

    typedef logic [7:0] byte_list_t[$];

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // rx_byte[7:0]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // data_byte[7:0], status_code[9:8], zero pad
    logic        m_tuser;   // is_status
    logic        m_tlast;

    int fail_count, pending, words_in, bytes_out, frames_out, frames_ok;

    // Idle rates in percent, long receiver hold-off requests
    int src_idle_pct = 13;
    int dst_idle_pct = 46;
    int hold_reqs    = 0;
    int holds_done   = 0;
    int hold_left    = 0;
    int phase_words  = 0;

    // Decoded frame content and its stuffed form on the link
    byte_list_t plain_q;
    byte_list_t wire_q;

    escaped_frame_checker_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    efc_result_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending),
        .words_in   (words_in),
        .bytes_out  (bytes_out),
        .frames_out (frames_out),
        .frames_ok  (frames_ok)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_reqs != holds_done)
            begin
                holds_done = holds_done + 1;
                hold_left  = 80;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Byte biased towards the two values that need stuffing
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0, 1:    return FRAME_MARK;
            2:       return ESC_MARK;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Offer one word, with random gaps, and wait for it to be taken
    task automatic send_word(input logic [7:0] b, input logic frame_end);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= frame_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        phase_words++;
    endtask

    task automatic send_wire();
        foreach (wire_q[i])
            send_word(wire_q[i], i == wire_q.size() - 1);
    endtask

    // Prefix the length, append the checksum, then stuff into wire_q
    task automatic seal_frame(input logic [31:0] len_skew, input logic [7:0] sum_skew);
        logic [31:0] len_val;
        logic [7:0]  sum;
        len_val = 32'(plain_q.size() + 5 - 1) + len_skew;
        for (int i = 0; i < 4; i++)
            plain_q.push_front(len_val[8*i +: 8]);
        sum = '0;
        foreach (plain_q[i])
            sum = sum + plain_q[i];
        plain_q.push_back(sum + sum_skew);
        wire_q.delete();
        foreach (plain_q[i])
        begin
            if (plain_q[i] == FRAME_MARK)
            begin
                wire_q.push_back(ESC_MARK);
                wire_q.push_back(ESC_OF_AA);
            end
            else if (plain_q[i] == ESC_MARK)
            begin
                wire_q.push_back(ESC_MARK);
                wire_q.push_back(ESC_OF_BB);
            end
            else
                wire_q.push_back(plain_q[i]);
        end
    endtask

    // One random frame: mostly well formed, the rest broken in one way or another
    task automatic random_frame();
        int          kind;
        int          n;
        int          pos;
        logic [7:0]  bad;
        logic [31:0] skew;
        kind = $urandom_range(99);
        n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        plain_q.delete();
        repeat (n)
            plain_q.push_back(rand_byte());
        if (kind < 55)
            seal_frame(32'd0, 8'd0);
        else if (kind < 65)
            seal_frame(32'd0, 8'($urandom_range(1, 255)));
        else if (kind < 72)
        begin
            case ($urandom_range(3))
                0:       skew = 32'd1;
                1:       skew = 32'd2;
                2:       skew = 32'hFFFF_FFFF;
                default: skew = $urandom;
            endcase
            seal_frame(skew, 8'd0);
        end
        else if (kind < 80)
        begin
            // bad escape pair somewhere before the final word
            seal_frame(32'd0, 8'd0);
            do
                bad = 8'($urandom_range(255));
            while (bad == ESC_OF_AA || bad == ESC_OF_BB);
            pos = $urandom_range(wire_q.size() - 1);
            wire_q.insert(pos, bad);
            wire_q.insert(pos, ESC_MARK);
        end
        else if (kind < 86)
        begin
            // short frame
            wire_q.delete();
            repeat ($urandom_range(1, 3))
                wire_q.push_back(rand_byte());
        end
        else if (kind < 92)
        begin
            // lone escape on the final word
            seal_frame(32'd0, 8'd0);
            wire_q.push_back(ESC_MARK);
        end
        else
        begin
            wire_q.delete();
            repeat ($urandom_range(1, 10))
                wire_q.push_back(rand_byte());
        end
        send_wire();
    endtask

    // Sender pauses until every expected result word has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: minimal good frame, escapes of both kinds, checksum fault
        plain_q.delete();
        seal_frame(32'd0, 8'd0);
        send_wire();
        plain_q.delete();
        plain_q.push_back(FRAME_MARK);
        plain_q.push_back(ESC_MARK);
        seal_frame(32'd0, 8'd0);
        send_wire();
        plain_q.delete();
        seal_frame(32'd0, 8'h01);
        send_wire();
        // single-word frame, too short
        send_word(8'h00, 1'b1);
        // bad escape landing on the final word
        send_word(ESC_MARK, 1'b0);
        send_word(8'h55, 1'b1);
        // trailing lone escape after one byte, and on its own
        send_word(8'h41, 1'b0);
        send_word(ESC_MARK, 1'b1);
        send_word(ESC_MARK, 1'b1);
        drain();

        // Random frames under three idling mixes
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 13;
                    dst_idle_pct = 46;
                end
                1:
                begin
                    src_idle_pct = 46;
                    dst_idle_pct = 13;
                end
                default:
                begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            phase_words = 0;
            while (phase_words < 145)
            begin
                if (phase != 1 && phase_words >= 40 && phase_words < 60)
                    hold_reqs <= hold_reqs + 1;
                random_frame();
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Covered %0d input words: directed cases, then random good, corrupted, short",
                 words_in);
        $display("and noise frames under three idle mixes with long output hold-offs;");
        $display("%0d bytes, %0d statuses (%0d clean) checked.",
                 bytes_out, frames_out, frames_ok);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[escaped_frame_checker_core.f]
rtl/core/efc_pkg.sv
rtl/core/efc_front.sv
rtl/core/efc_queue.sv
rtl/core/efc_back.sv
rtl/core/escaped_frame_checker_core.sv
tb/sv/efc_result_checker.sv
tb/sv/escaped_frame_checker_core_test.sv
